>>> rtl/integer_field_formatter_macros.svh
// assertion macros for the integer field formatter
`ifndef INTEGER_FIELD_FORMATTER_MACROS_SVH
`define INTEGER_FIELD_FORMATTER_MACROS_SVH

// property must hold on every rising clock edge outside reset
`define IFF_ASSERT(label, prop, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (prop)) else $error(msg);

`endif

>>> rtl/iff_pkg.sv
package iff_pkg;

	localparam int MAX_FIELD = 64;
	localparam int CNT_W = 7;

	typedef enum logic [2:0] {
		CMD_SDEC = 3'd0,
		CMD_UDEC = 3'd1,
		CMD_OCT  = 3'd2,
		CMD_HEXL = 3'd3,
		CMD_HEXU = 3'd4
	} cmd_t;

	typedef enum logic [1:0] {
		SZ_INT   = 2'd0,
		SZ_SHORT = 2'd1,
		SZ_LONG  = 2'd2
	} size_mod_t;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_CONV,
		ST_PLAN,
		ST_EMIT,
		ST_DRAIN
	} state_t;

	// controller to datapath
	typedef struct packed {
		logic load;
		logic conv_step;
		logic plan;
		logic emit;
	} ctrl_t;

	// datapath to controller
	typedef struct packed {
		logic conv_done;
		logic empty;
		logic last_char;
	} stat_t;

endpackage

>>> rtl/integer_field_formatter.sv
// Integer field formatter: takes one printf-style integer conversion request per
// s_axis word (command, value, size, flags, width, precision) and sends the
// formatted characters one per m_axis word, tlast on the final one, at most 64.
// A request is accepted and loaded, then converted: one step per digit for
// octal and hex (up to 22 digits), four steps per digit for decimal since ten is
// divided out in 16-bit chunks (up to 20 digits); the controller then sees the
// conversion finished, plans the field, and emits one character per cycle
// while the receiver keeps up; receiver stalls hold the emission.
// A field that is empty yields no word. The next request is taken in the
// cycle after the last character has entered the output register.
`include "integer_field_formatter_macros.svh"
module integer_field_formatter
	import iff_pkg::*;
(
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_axis_tvalid,
	output logic        s_axis_tready,
	// command[2:0], value[66:3], size_mod[68:67], left_align[69], plus_sign[70],
	// space_sign[71], zero_pad[72], alt_form[73], field_width[80:74],
	// precision[86:81], has_precision[87]
	input  logic [87:0] s_axis_tdata,
	output logic        m_axis_tvalid,
	input  logic        m_axis_tready,
	// out_char[7:0]
	output logic [7:0]  m_axis_tdata,
	output logic        m_axis_tlast
);

	ctrl_t      cmd;
	stat_t      st;
	logic       out_load;
	logic [7:0] ch;

	// output register frees when taken
	logic out_free;
	assign out_free = !m_axis_tvalid || m_axis_tready;

	iff_ctrl u_ctrl (
		.clk(clk), .arst_n(arst_n),
		.in_valid(s_axis_tvalid), .in_ready(s_axis_tready),
		.out_load(out_load), .out_free(out_free), .st(st), .cmd(cmd)
	);

	iff_dp u_dp (
		.clk(clk), .arst_n(arst_n), .cmd(cmd),
		.in_cmd(s_axis_tdata[2:0]), .value(s_axis_tdata[66:3]),
		.size_mod(s_axis_tdata[68:67]), .left_align(s_axis_tdata[69]),
		.plus_sign(s_axis_tdata[70]), .space_sign(s_axis_tdata[71]),
		.zero_pad(s_axis_tdata[72]), .alt_form(s_axis_tdata[73]),
		.field_width(s_axis_tdata[80:74]), .precision(s_axis_tdata[86:81]),
		.has_precision(s_axis_tdata[87]), .st(st), .out_char(ch)
	);

	// output word register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) m_axis_tvalid <= 1'b0;
		else if (out_load) m_axis_tvalid <= 1'b1;
		else if (m_axis_tready) m_axis_tvalid <= 1'b0;
	end
	always_ff @(posedge clk) begin
		if (out_load) begin
			m_axis_tdata <= ch;
			m_axis_tlast <= st.last_char;
		end
	end

	`IFF_ASSERT(a_load_free, out_load |-> out_free, "output overwritten")
	`IFF_ASSERT(a_one_cmd, $onehot0({cmd.load, cmd.conv_step, cmd.plan, cmd.emit}), "cmd clash")
	`IFF_ASSERT(a_no_take_busy, (cmd.emit || cmd.conv_step) |-> !s_axis_tready, "input busy")

endmodule

>>> rtl/iff_ctrl.sv
module iff_ctrl
	import iff_pkg::*;
(
	input  logic  clk,
	input  logic  arst_n,
	input  logic  in_valid,
	output logic  in_ready,
	output logic  out_load,
	input  logic  out_free,
	input  stat_t st,
	output ctrl_t cmd
);

	state_t state_q, state_nx;

	// state register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) state_q <= ST_IDLE;
		else state_q <= state_nx;
	end

	// next state and commands
	always_comb begin
		state_nx = state_q;
		cmd = '0;
		in_ready = 1'b0;
		out_load = 1'b0;
		unique case (state_q)
			ST_IDLE: begin
				in_ready = 1'b1;
				if (in_valid) begin
					cmd.load = 1'b1;
					state_nx = ST_CONV;
				end
			end
			ST_CONV: begin
				if (st.conv_done) state_nx = ST_PLAN;
				else cmd.conv_step = 1'b1;
			end
			ST_PLAN: begin
				cmd.plan = 1'b1;
				state_nx = ST_EMIT;
			end
			ST_EMIT: begin
				if (st.empty) state_nx = ST_IDLE;
				else if (out_free) begin
					cmd.emit = 1'b1;
					out_load = 1'b1;
					if (st.last_char) state_nx = ST_IDLE;
				end
			end
			ST_DRAIN: state_nx = ST_IDLE;
			default: state_nx = ST_IDLE;
		endcase
	end

endmodule

>>> rtl/iff_dp.sv
module iff_dp
	import iff_pkg::*;
(
	input  logic        clk,
	input  logic        arst_n,
	input  ctrl_t       cmd,
	input  logic [2:0]  in_cmd,
	input  logic [63:0] value,
	input  logic [1:0]  size_mod,
	input  logic        left_align,
	input  logic        plus_sign,
	input  logic        space_sign,
	input  logic        zero_pad,
	input  logic        alt_form,
	input  logic [6:0]  field_width,
	input  logic [5:0]  precision,
	input  logic        has_precision,
	output stat_t       st,
	output logic [7:0]  out_char
);

	logic [2:0]  cmd_q;
	logic        left_q, plus_q, space_q, zpad_q, alt_q, hasp_q, neg_q, magz_q;
	logic [6:0]  width_q;
	logic [5:0]  prec_q;
	logic [63:0] rem_q;
	logic [1:0]  sub_q;
	logic [3:0]  r_q;
	logic [3:0]  dig_q [22];
	logic [4:0]  ndig_q;
	logic [8:0]  pos_q;
	logic [8:0]  pad_q, zeros_q, plen_q, total_q;
	logic [8:0]  pad_end_q, pre_end_q, zpad_end_q, zero_end_q;
	logic        zmode_q;

	// conversion kind decode
	logic        is_sdec, is_oct, is_hex, upper;
	logic [2:0]  ck;
	always_comb begin
		ck = (in_cmd > 3'd4) ? CMD_UDEC : in_cmd;
		is_sdec = (ck == CMD_SDEC);
		is_oct = (ck == CMD_OCT);
		is_hex = (ck == CMD_HEXL) || (ck == CMD_HEXU);
		upper = (ck == CMD_HEXU);
	end

	// truncate and take the magnitude
	logic [63:0] trunc, mag_in;
	logic        neg_in;
	always_comb begin
		case (size_mod)
			SZ_SHORT: begin
				trunc = {48'd0, value[15:0]};
				neg_in = is_sdec && value[15];
				mag_in = neg_in ? {48'd0, 16'(-value[15:0])} : trunc;
			end
			SZ_INT: begin
				trunc = {32'd0, value[31:0]};
				neg_in = is_sdec && value[31];
				mag_in = neg_in ? {32'd0, 32'(-value[31:0])} : trunc;
			end
			default: begin
				trunc = value;
				neg_in = is_sdec && value[63];
				mag_in = neg_in ? -value : value;
			end
		endcase
	end

	// octal and hex take one digit per step by shifting; decimal divides by ten
	// in four 16-bit chunks, most significant first, one chunk per step
	logic [63:0] quo;
	logic [3:0]  dig;
	logic [2:0]  k;
	logic [19:0] part;
	logic [39:0] prod;
	logic [15:0] part_quo;
	logic [3:0]  part_rem;
	logic        step_last;
	always_comb begin
		k = cmd_q;
		quo = rem_q;
		dig = '0;
		// chunk over ten by reciprocal multiply, exact for chunks below 655360
		part = {r_q, rem_q[63:48]};
		prod = {20'd0, part} * 40'd838861;
		part_quo = prod[38:23];
		part_rem = 4'(part - ({4'd0, part_quo} * 20'd10));
		step_last = 1'b1;
		if (k == CMD_OCT) begin
			quo = rem_q >> 3;
			dig = {1'b0, rem_q[2:0]};
		end else if (k == CMD_HEXL || k == CMD_HEXU) begin
			quo = rem_q >> 4;
			dig = rem_q[3:0];
		end else begin
			quo = {rem_q[47:0], part_quo};
			dig = part_rem;
			step_last = (sub_q == 2'd3);
		end
	end

	assign st.conv_done = (rem_q == '0) && (sub_q == '0);

	// plan arithmetic
	logic [8:0] nd, minp, zr, pl, body, pd;
	logic       zm;
	always_comb begin
		nd = {4'd0, ndig_q};
		if (magz_q && !(hasp_q && prec_q == '0)) nd = 9'd1;
		minp = hasp_q ? {3'd0, prec_q} : 9'd1;
		zr = (minp > nd) ? minp - nd : '0;
		if (alt_q && cmd_q == CMD_OCT && zr == '0 && (nd == '0 || !magz_q)) zr = 9'd1;
		pl = '0;
		if (cmd_q == CMD_SDEC) pl = (neg_q || plus_q || space_q) ? 9'd1 : 9'd0;
		else if (alt_q && (cmd_q == CMD_HEXL || cmd_q == CMD_HEXU) && !magz_q) pl = 9'd2;
		body = pl + zr + nd;
		pd = ({2'd0, width_q} > body) ? {2'd0, width_q} - body : '0;
		zm = zpad_q && !left_q && !hasp_q;
	end

	// registers
	always_ff @(posedge clk) begin
		if (cmd.load) begin
			cmd_q <= (in_cmd > 3'd4) ? CMD_UDEC : in_cmd;
			left_q <= left_align; plus_q <= plus_sign; space_q <= space_sign;
			zpad_q <= zero_pad; alt_q <= alt_form; hasp_q <= has_precision;
			width_q <= field_width; prec_q <= precision;
			neg_q <= neg_in; magz_q <= (mag_in == '0);
			rem_q <= mag_in; ndig_q <= '0;
			sub_q <= '0; r_q <= '0;
		end else if (cmd.conv_step) begin
			rem_q <= quo;
			if (step_last) begin
				dig_q[ndig_q] <= dig;
				ndig_q <= ndig_q + 5'd1;
				sub_q <= '0;
				r_q <= '0;
			end else begin
				sub_q <= sub_q + 2'd1;
				r_q <= part_rem;
			end
		end
		if (cmd.plan) begin
			if (magz_q && !(hasp_q && prec_q == '0)) begin
				dig_q[0] <= 4'd0;
				ndig_q <= 5'd1;
			end
			pad_q <= pd; zeros_q <= zr; plen_q <= pl; zmode_q <= zm;
			total_q <= body + pd;
			pad_end_q <= (!left_q && !zm) ? pd : 9'd0;
			pre_end_q <= ((!left_q && !zm) ? pd : 9'd0) + pl;
			zpad_end_q <= ((!left_q && !zm) ? pd : 9'd0) + pl + (zm ? pd : 9'd0);
			zero_end_q <= pd + pl + zr - (left_q ? pd : 9'd0);
			pos_q <= '0;
		end else if (cmd.emit) begin
			pos_q <= pos_q + 9'd1;
		end
	end

	// character at the current position
	logic [8:0] di;
	logic [3:0] dv;
	logic [8:0] tot_cap;
	always_comb begin
		di = {4'd0, ndig_q} - 9'd1 - (pos_q - zero_end_q);
		dv = dig_q[di[4:0]];
		if (pos_q < pad_end_q) out_char = 8'd32;
		else if (pos_q < pre_end_q) begin
			if (cmd_q == CMD_SDEC)
				out_char = neg_q ? 8'd45 : (plus_q ? 8'd43 : 8'd32);
			else if (pos_q == pad_end_q) out_char = 8'd48;
			else out_char = (cmd_q == CMD_HEXU) ? 8'd88 : 8'd120;
		end else if (pos_q < zero_end_q) out_char = 8'd48;
		else if (pos_q < zero_end_q + {4'd0, ndig_q})
			out_char = (dv < 4'd10) ? 8'd48 + {4'd0, dv}
				: ((cmd_q == CMD_HEXU) ? 8'd55 : 8'd87) + {4'd0, dv};
		else out_char = 8'd32;
		tot_cap = (total_q > 9'(MAX_FIELD)) ? 9'(MAX_FIELD) : total_q;
	end

	assign st.empty = (total_q == '0);
	assign st.last_char = (pos_q + 9'd1 == tot_cap);

	logic unused;
	assign unused = is_oct ^ is_hex ^ upper ^ (|trunc) ^ (|pad_q) ^ (|zeros_q)
		^ (|plen_q) ^ zmode_q ^ (|zpad_end_q) ^ arst_n ^ prod[39] ^ (|prod[22:0]);

endmodule

>>> tb/integer_field_formatter_checker.sv
`timescale 1ns / 100ps
module integer_field_formatter_checker
	import iff_pkg::*;
(
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_axis_tvalid,
	input  logic        s_axis_tready,
	input  logic [87:0] s_axis_tdata,
	input  logic        m_axis_tvalid,
	input  logic        m_axis_tready,
	input  logic [7:0]  m_axis_tdata,
	input  logic        m_axis_tlast,
	output int          fail_count,
	output int          pending
);

	typedef struct packed {
		logic [7:0] ch;
		logic       lst;
	} char_word_t;

	char_word_t field_chars_q[$];

	// format one request into the expected character words
	function automatic void format_field(input logic [87:0] req);
		logic [2:0]  cmd;
		logic [63:0] mag, t;
		logic [1:0]  sz;
		logic        lft, pls, spc, zp, alt, hasp, neg, upper, zmode;
		int          wid, prec, base, ndig, zeros, plen, body, pad, n, k, d;
		logic [7:0]  digs[32];
		logic [7:0]  pre[2];
		logic [7:0]  buf_q[$];
		cmd = req[2:0];
		mag = req[66:3];
		sz = req[68:67];
		lft = req[69];
		pls = req[70];
		spc = req[71];
		zp = req[72];
		alt = req[73];
		wid = req[80:74];
		prec = req[86:81];
		hasp = req[87];
		neg = 1'b0;
		ndig = 0;
		plen = 0;
		if (cmd > CMD_HEXU) cmd = CMD_UDEC;
		base = (cmd == CMD_OCT) ? 8 : (cmd >= CMD_HEXL) ? 16 : 10;
		upper = (cmd == CMD_HEXU);
		// truncate and take magnitude for signed decimal
		if (sz == SZ_SHORT) begin
			mag = mag & 64'hFFFF;
			if (cmd == CMD_SDEC && mag[15]) begin
				neg = 1'b1;
				mag = 64'h10000 - mag;
			end
		end else if (sz == SZ_INT) begin
			mag = mag & 64'hFFFF_FFFF;
			if (cmd == CMD_SDEC && mag[31]) begin
				neg = 1'b1;
				mag = 64'h1_0000_0000 - mag;
			end
		end else if (cmd == CMD_SDEC && mag[63]) begin
			neg = 1'b1;
			mag = -mag;
		end
		t = mag;
		while (t != 0) begin
			d = 32'(t % base);
			digs[ndig] = 8'((d < 10) ? 48 + d : (upper ? 65 : 97) + d - 10);
			ndig++;
			t = t / base;
		end
		if (mag == 0 && !(hasp && prec == 0)) begin
			digs[ndig] = "0";
			ndig++;
		end
		n = hasp ? prec : 1;
		zeros = (n > ndig) ? n - ndig : 0;
		if (alt && base == 8 && zeros == 0 && (ndig == 0 || mag != 0)) zeros = 1;
		if (cmd == CMD_SDEC) begin
			if (neg) begin pre[0] = "-"; plen = 1; end
			else if (pls) begin pre[0] = "+"; plen = 1; end
			else if (spc) begin pre[0] = " "; plen = 1; end
		end else if (alt && base == 16 && mag != 0) begin
			pre[0] = "0";
			pre[1] = upper ? "X" : "x";
			plen = 2;
		end
		body = plen + zeros + ndig;
		pad = (wid > body) ? wid - body : 0;
		zmode = zp && !lft && !hasp;
		if (!lft && !zmode) repeat (pad) buf_q.push_back(" ");
		for (k = 0; k < plen; k++) buf_q.push_back(pre[k]);
		if (zmode) repeat (pad) buf_q.push_back("0");
		repeat (zeros) buf_q.push_back("0");
		for (k = ndig; k > 0; k--) buf_q.push_back(digs[k - 1]);
		if (lft) repeat (pad) buf_q.push_back(" ");
		n = (buf_q.size() < MAX_FIELD) ? buf_q.size() : MAX_FIELD;
		for (k = 0; k < n; k++) field_chars_q.push_back({buf_q[k], k + 1 == n});
	endfunction

	// watch both channels and compare
	always @(posedge clk or negedge arst_n) begin
		char_word_t exp_w;
		int errs;
		errs = 0;
		if (!arst_n) begin
			fail_count <= 0;
			pending <= 0;
		end else begin
			if (s_axis_tvalid && s_axis_tready) format_field(s_axis_tdata);
			if (m_axis_tvalid && m_axis_tready) begin
				if (field_chars_q.size() == 0) begin
					$error("unexpected word out_char=%h", m_axis_tdata);
					errs++;
				end else begin
					exp_w = field_chars_q.pop_front();
					if (m_axis_tdata !== exp_w.ch) begin
						$error("out_char expected %h actual %h", exp_w.ch, m_axis_tdata);
						errs++;
					end
					if (m_axis_tlast !== exp_w.lst) begin
						$error("last expected %b actual %b", exp_w.lst, m_axis_tlast);
						errs++;
					end
				end
			end
			fail_count <= fail_count + errs;
			pending <= field_chars_q.size();
		end
	end

endmodule

>>> tb/integer_field_formatter_tb.sv
`timescale 1ns / 100ps
module integer_field_formatter_tb
	import iff_pkg::*;
;

	logic        clk;
	logic        arst_n;
	logic        s_axis_tvalid;
	logic        s_axis_tready;
	logic [87:0] s_axis_tdata;
	logic        m_axis_tvalid;
	logic        m_axis_tready;
	logic [7:0]  m_axis_tdata;
	logic        m_axis_tlast;
	int          fail_count;
	int          pending;
	int          send_idle_pct;
	int          recv_idle_pct;
	logic        hold_off;

	integer_field_formatter u_top (.*);

	integer_field_formatter_checker u_chk (.*);

	always begin
		clk = 1'b0;
		#5;
		clk = 1'b1;
		#5;
	end

	// receiver: random stall plus optional long hold-off
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_axis_tready <= 1'b0;
		end else begin
			m_axis_tready <= !hold_off && ($urandom_range(99) >= recv_idle_pct);
		end
	end

	function automatic logic [87:0] pack_req(input logic [2:0] cmd, input logic [63:0] v,
		input logic [1:0] sz, input logic [4:0] flags, input logic [6:0] wid,
		input logic [5:0] prec, input logic hasp);
		// flags: left, plus, space, zero, alt from bit 0 up
		return {hasp, prec, wid, flags[4], flags[3], flags[2], flags[1], flags[0],
			sz, v, cmd};
	endfunction

	task automatic send_word(input logic [87:0] req);
		while ($urandom_range(99) < send_idle_pct) begin
			s_axis_tvalid <= 1'b0;
			@(posedge clk);
		end
		s_axis_tvalid <= 1'b1;
		s_axis_tdata <= req;
		@(posedge clk);
		while (!s_axis_tready) @(posedge clk);
	endtask

	task automatic send_random;
		logic [63:0] v;
		logic [6:0]  wid;
		v = {$urandom, $urandom};
		case ($urandom_range(3))
			0: v = v >> $urandom_range(63);
			1: v = 64'($urandom_range(20));
			default: ;
		endcase
		wid = ($urandom_range(7) == 0) ? 7'($urandom_range(127)) : 7'($urandom_range(24));
		send_word(pack_req(3'($urandom_range(7)), v, 2'($urandom_range(3)),
			5'($urandom_range(31)), wid, 6'($urandom_range(63)), 1'($urandom_range(1))));
	endtask

	task automatic drain;
		s_axis_tvalid <= 1'b0;
		@(posedge clk);
		while (pending != 0) @(posedge clk);
		repeat (200) @(posedge clk);
	endtask

	initial begin
		#10000000;
		$display("Regression FAIL");
		$finish;
	end

	initial begin
		arst_n = 1'b0;
		s_axis_tvalid = 1'b0;
		s_axis_tdata = '0;
		hold_off = 1'b0;
		send_idle_pct = 24;
		recv_idle_pct = 77;
		repeat (7) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		// directed: extremes, every command, special cases
		send_word(pack_req(CMD_SDEC, 64'h8000_0000_0000_0000, SZ_LONG, 5'b0, 0, 0, 0));
		send_word(pack_req(CMD_UDEC, '1, SZ_LONG, 5'b0, 0, 0, 0));
		send_word(pack_req(CMD_SDEC, 64'hFFFF_8000, SZ_SHORT, 5'b00010, 8, 0, 0));
		send_word(pack_req(CMD_SDEC, 64'h7FFF_FFFF, SZ_INT, 5'b00110, 12, 0, 0));
		send_word(pack_req(CMD_SDEC, 64'd42, SZ_INT, 5'b00100, 6, 0, 0));
		send_word(pack_req(CMD_OCT, 64'd8, SZ_INT, 5'b10000, 0, 0, 0));
		send_word(pack_req(CMD_OCT, 64'd0, SZ_INT, 5'b10000, 0, 0, 1));
		send_word(pack_req(CMD_HEXL, 64'hDEAD_BEEF, SZ_LONG, 5'b11000, 14, 0, 0));
		send_word(pack_req(CMD_HEXU, 64'hABCD, SZ_SHORT, 5'b10001, 12, 6, 1));
		send_word(pack_req(CMD_HEXL, 64'd0, SZ_INT, 5'b10000, 4, 0, 0));
		send_word(pack_req(CMD_UDEC, 64'd0, SZ_INT, 5'b00000, 0, 0, 1));
		send_word(pack_req(CMD_SDEC, 64'd0, SZ_INT, 5'b00000, 5, 0, 1));
		send_word(pack_req(CMD_UDEC, 64'd7, SZ_INT, 5'b01001, 10, 3, 1));
		send_word(pack_req(CMD_UDEC, 64'd7, SZ_INT, 5'b01001, 10, 0, 0));
		send_word(pack_req(CMD_OCT, 64'd5, SZ_INT, 5'b00110, 4, 0, 0));
		send_word(pack_req(3'd7, '1, 2'd3, 5'b11111, 127, 63, 1));
		send_word(pack_req(3'd5, 64'd99, 2'd3, 5'b00000, 64, 62, 1));
		send_word(pack_req(CMD_SDEC, 64'd1, SZ_LONG, 5'b00000, 100, 0, 0));
		send_word(pack_req(CMD_SDEC, 64'd1, SZ_LONG, 5'b00001, 65, 0, 0));
		// long receiver hold-off while requests keep coming
		hold_off <= 1'b1;
		fork
			begin
				repeat (400) @(posedge clk);
				hold_off <= 1'b0;
			end
			repeat (6) send_random();
		join
		repeat (130) send_random();
		send_idle_pct = 77;
		recv_idle_pct = 24;
		repeat (130) send_random();
		send_idle_pct = 0;
		recv_idle_pct = 0;
		repeat (130) send_random();
		drain();
		if (fail_count == 0) begin
			$display("Regression PASS");
		end else begin
			$display("Regression FAIL");
		end
		$finish;
	end

endmodule

>>> files.f
+incdir+rtl
rtl/iff_pkg.sv
rtl/iff_ctrl.sv
rtl/iff_dp.sv
rtl/integer_field_formatter.sv
tb/integer_field_formatter_checker.sv
tb/integer_field_formatter_tb.sv
